@@ sv/sgm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sgm_pkg;

  // Width used for the frame dimension end compares; covers dimensions up to 8191.
  localparam int DIM_W = 13;
  localparam int CFG_W = 11;
  localparam int CFG_INDEX_W = 1;
  localparam int SUM_W = 17;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 11'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 11'd480;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [7:0] magnitude;
    logic [9:0] center_x;
    logic [9:0] center_y;
    logic       frame_last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WINDOW,
    ST_GRAD,
    ST_SQUARE,
    ST_ROOT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic window_load;
    logic grad_load;
    logic square_load;
    logic root_step;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic produce;
    logic root_last;
    logic out_free;
  } status_t;

  // Last usable index of a dimension after clamping the register to 3..hi.
  function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_W-1:0] v,
                                                input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] ve;
    ve = DIM_W'(v);
    if (ve < DIM_W'(3)) begin
      return DIM_W'(2);
    end
    if (ve > hi) begin
      return hi - DIM_W'(1);
    end
    return ve - DIM_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ sv/sgm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/sgm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sgm_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pixel_valid,
  output logic                 pixel_stall,
  input  wire sgm_pkg::status_t status,
  output sgm_pkg::cmd_t        cmd
);

  sgm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sgm_pkg::ST_IDLE: begin
        if (pixel_valid) begin
          state_next = sgm_pkg::ST_READ;
        end
      end
      sgm_pkg::ST_READ:   state_next = sgm_pkg::ST_WINDOW;
      sgm_pkg::ST_WINDOW: begin
        state_next = status.produce ? sgm_pkg::ST_GRAD : sgm_pkg::ST_IDLE;
      end
      sgm_pkg::ST_GRAD:   state_next = sgm_pkg::ST_SQUARE;
      sgm_pkg::ST_SQUARE: state_next = sgm_pkg::ST_ROOT;
      sgm_pkg::ST_ROOT: begin
        if (status.root_last) begin
          state_next = sgm_pkg::ST_EMIT;
        end
      end
      sgm_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_next = sgm_pkg::ST_IDLE;
        end
      end
      default: state_next = sgm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    pixel_stall = 1'b1;
    case (state)
      sgm_pkg::ST_IDLE: begin
        pixel_stall = 1'b0;
        cmd.accept = pixel_valid;
      end
      sgm_pkg::ST_READ:   ;
      sgm_pkg::ST_WINDOW: cmd.window_load = 1'b1;
      sgm_pkg::ST_GRAD:   cmd.grad_load = 1'b1;
      sgm_pkg::ST_SQUARE: cmd.square_load = 1'b1;
      sgm_pkg::ST_ROOT:   cmd.root_step = 1'b1;
      sgm_pkg::ST_EMIT:   cmd.emit_load = status.out_free;
      default:            ;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/sgm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sgm_datapath #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [sgm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [sgm_pkg::CFG_W-1:0]         cfg_data,
  input  wire sgm_pkg::pixel_t                   pixel_data,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output sgm_pkg::result_t                       result_data,
  input  wire sgm_pkg::cmd_t                     cmd,
  output sgm_pkg::status_t                       status
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int XW = (CW > 10) ? CW : 10;
  localparam int YW = (RW > 10) ? RW : 10;
  localparam int DW = sgm_pkg::DIM_W;
  localparam int SW = sgm_pkg::SUM_W;

  logic [sgm_pkg::CFG_W-1:0] image_width, image_height;
  logic [CW-1:0] col_cnt, col_reg;
  logic [RW-1:0] row_cnt, row_reg;
  logic [7:0]    px_reg;
  logic [7:0]    win [9];
  logic [7:0]    top_rd, mid_rd;
  logic [DW-1:0] w_last, h_last;
  logic          last_col, last_row, frame_last;
  logic signed [10:0] gx, gy;
  logic signed [8:0]  gx_s, gy_s;
  logic signed [17:0] gx_sq, gy_sq;
  logic [SW-1:0] root_n, root_val, root_bit;
  logic [SW:0]   trial;
  logic [XW-1:0] cx_full;
  logic [YW-1:0] cy_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= sgm_pkg::IMAGE_WIDTH_RESET;
      image_height <= sgm_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sgm_pkg::REG_IMAGE_WIDTH:  image_width <= cfg_data;
        sgm_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_last = sgm_pkg::dim_last(image_width, DW'(MAX_WIDTH));
  assign h_last = sgm_pkg::dim_last(image_height, DW'(MAX_HEIGHT));
  assign last_col = DW'(col_reg) >= w_last;
  assign last_row = DW'(row_reg) >= h_last;

  // The top line takes the old middle line; the middle line takes the new pixel.
  sgm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_top_line (
    .clk(clk), .we(cmd.window_load), .waddr(col_reg), .wdata(mid_rd),
    .raddr(col_reg), .rdata(top_rd)
  );

  sgm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_mid_line (
    .clk(clk), .we(cmd.window_load), .waddr(col_reg), .wdata(px_reg),
    .raddr(col_reg), .rdata(mid_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_reg <= pixel_data.pixel;
      col_reg <= pixel_data.frame_start ? '0 : col_cnt;
      row_reg <= pixel_data.frame_start ? '0 : row_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (cmd.window_load) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_reg + RW'(1);
      end else begin
        col_cnt <= col_reg + CW'(1);
        row_cnt <= row_reg;
      end
      for (int r = 0; r < 3; r++) begin
        win[r*3] <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= top_rd;
      win[5] <= mid_rd;
      win[8] <= px_reg;
    end
  end

  assign status.produce = (row_reg >= RW'(2)) && (col_reg >= CW'(2));

  always_ff @(posedge clk) begin
    if (cmd.window_load) begin
      frame_last <= last_col && last_row;
    end
  end

  function automatic logic signed [10:0] ext(input logic [7:0] p);
    return $signed({3'b000, p});
  endfunction

  assign gx = ext(win[0]) - ext(win[2]) + ((ext(win[3]) - ext(win[5])) <<< 1)
            + ext(win[6]) - ext(win[8]);
  assign gy = ext(win[6]) + (ext(win[7]) <<< 1) + ext(win[8])
            - ext(win[0]) - (ext(win[1]) <<< 1) - ext(win[2]);

  // Arithmetic shift by two rounds toward minus infinity.
  always_ff @(posedge clk) begin
    if (cmd.grad_load) begin
      gx_s <= gx[10:2];
      gy_s <= gy[10:2];
    end
  end

  assign gx_sq = gx_s * gx_s;
  assign gy_sq = gy_s * gy_s;
  assign trial = (SW+1)'(root_val) + (SW+1)'(root_bit);

  // Digit-by-digit square root, two operand bits per step.
  always_ff @(posedge clk) begin
    if (cmd.square_load) begin
      root_n <= gx_sq[SW-1:0] + gy_sq[SW-1:0];
      root_val <= '0;
      root_bit <= SW'(1) << (SW - 1);
    end else if (cmd.root_step) begin
      if ((SW+1)'(root_n) >= trial) begin
        root_n <= root_n - trial[SW-1:0];
        root_val <= (root_val >> 1) + root_bit;
      end else begin
        root_val <= root_val >> 1;
      end
      root_bit <= root_bit >> 2;
    end
  end

  assign status.root_last = root_bit[0];
  assign status.out_free = !result_valid || !result_stall;

  assign cx_full = XW'(col_reg) - XW'(1);
  assign cy_full = YW'(row_reg) - YW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      result_data.magnitude <= (root_val > SW'(255)) ? 8'd255 : root_val[7:0];
      result_data.center_x <= cx_full[9:0];
      result_data.center_y <= cy_full[9:0];
      result_data.frame_last <= frame_last;
    end
  end

endmodule

`default_nettype wire

@@ sv/sobel_gradient_magnitude.sv @@
// A pixel's pass runs the registered line-store read, window, gradient, square, nine-step
// square root and emit states before its result shows; a border pixel ends after window.
// The next pixel is taken only once the pass has ended and the controller is idle again.
// Reset: synchronous, active high; clears counters, window, sizes (640 x 480) and valid.
// The line store is not cleared; it holds only what the pixel stream has written.
`timescale 1ns / 1ps
`default_nettype none

// 3x3 Sobel gradient magnitude over a raster pixel stream.
//
// Each pixel transfer starts one pass of the controller. The pixel's column
// addresses both line buffers; in the next cycle the old top and middle bytes
// arrive, the buffers are rewritten (middle line moves to top, pixel goes to
// middle) and the 3x3 window shifts left by one column. Pixels in the first
// two rows or columns end the pass there and produce no result.
//
// For a full window the datapath forms the horizontal and vertical sums,
// shifts each right by two with floor rounding, squares and adds them, and
// takes an exact floor square root in nine iterations. The root, saturated
// to 255, is tagged with the window centre and placed in the output register.
// The output register lets the next pixel transfer begin while a result still
// waits to be taken; the controller only waits when a second result is ready
// before the first has left.
//
// Frame position wraps by the configured width and height, clamped to the
// supported range, and frame_start forces the pixel to row 0, column 0.
module sobel_gradient_magnitude #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [sgm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sgm_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                            pixel_valid,
  output logic                                 pixel_stall,
  input  wire sgm_pkg::pixel_t                 pixel_data,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output sgm_pkg::result_t                     result_data
);

  sgm_pkg::cmd_t    cmd;
  sgm_pkg::status_t status;

  // Sequencer: one pass per pixel, states from line read to result load.
  sgm_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .status(status),
    .cmd(cmd)
  );

  // Line buffers, window, gradient arithmetic, root unit and output register.
  sgm_datapath #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel_data(pixel_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data(result_data),
    .cmd(cmd),
    .status(status)
  );

endmodule

`default_nettype wire

@@ sv/sgm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sgm_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             pixel_valid,
  input wire logic             pixel_stall,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire sgm_pkg::result_t result_data
);

  // A stalled result stays and keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("stalled result changed or dropped");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A pixel transfer always starts a pass, and pixels are held off after it.
  assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall |=> pixel_stall)
    else $error("pixel taken in the cycle after a transfer");

  // A new result is only loaded while the input side is held off.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pixel_stall))
    else $error("result loaded while pixels were being taken");

endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (
  .clk(clk),
  .rst(rst),
  .pixel_valid(pixel_valid),
  .pixel_stall(pixel_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result_data(result_data)
);

`default_nettype wire
